@@ rtl/core/efd_pkg.sv @@
`timescale 1ns / 1ps

package efd_pkg;

  localparam logic [31:0] CrcPoly        = 32'hEDB88320;
  localparam logic [31:0] CrcOnes        = 32'hFFFFFFFF;
  localparam logic [31:0] PreludeBytes   = 32'd12;
  localparam logic [31:0] OverheadBytes  = 32'd16;
  localparam logic [31:0] MaxMsgReset    = 32'd16777216;
  localparam logic [31:0] MaxHdrReset    = 32'd131072;
  localparam int          CfgAddrW       = 3;

  // Wire tags with special handling.
  localparam logic [7:0] WireByteArray = 8'd6;
  localparam logic [7:0] WireString    = 8'd7;
  localparam logic [7:0] WireUuid      = 8'd9;

  // Byte classification codes.
  localparam logic [3:0] KindLenPrelude = 4'd0;
  localparam logic [3:0] KindPreludeCrc = 4'd1;
  localparam logic [3:0] KindNameLen    = 4'd2;
  localparam logic [3:0] KindName       = 4'd3;
  localparam logic [3:0] KindTag        = 4'd4;
  localparam logic [3:0] KindValLen     = 4'd5;
  localparam logic [3:0] KindValData    = 4'd6;
  localparam logic [3:0] KindPayload    = 4'd7;
  localparam logic [3:0] KindMsgCrc     = 4'd8;
  localparam logic [3:0] KindDiscard    = 4'd9;

  // Status codes.
  localparam logic [2:0] StatOk        = 3'd0;
  localparam logic [2:0] StatPreCrc    = 3'd1;
  localparam logic [2:0] StatBounds    = 3'd2;
  localparam logic [2:0] StatBadName   = 3'd3;
  localparam logic [2:0] StatBadValue  = 3'd4;
  localparam logic [2:0] StatMsgCrc    = 3'd5;
  localparam logic [2:0] StatHalted    = 3'd6;

  // Register indexes on the configuration port.
  localparam logic RegMaxMsg = 1'b0;
  localparam logic RegMaxHdr = 1'b1;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_NAME  = 2'd1,
    FAULT_VALUE = 2'd2
  } fault_t;

  typedef enum logic [8:0] {
    PH_PRELUDE  = 9'b000000001,
    PH_NAME_LEN = 9'b000000010,
    PH_NAME     = 9'b000000100,
    PH_TAG      = 9'b000001000,
    PH_VAL_LEN  = 9'b000010000,
    PH_VAL_DATA = 9'b000100000,
    PH_SKIP     = 9'b001000000,
    PH_PAYLOAD  = 9'b010000000,
    PH_MCRC     = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [31:0] max_message_bytes;
    logic [31:0] max_header_block_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [3:0]  byte_kind;
    logic [3:0]  value_tag;
    logic [63:0] fixed_value;
    logic        value_complete;
    logic        frame_last;
    logic [2:0]  status;
  } res_t;

  // One entry of the byte-wise CRC table; constant-folds to a 256-entry ROM.
  function automatic logic [31:0] crc_tbl(input logic [7:0] idx);
    logic [31:0] c;
    c = {24'd0, idx};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/core/efd_in_if.sv @@
`timescale 1ns / 1ps

interface efd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

@@ rtl/core/efd_out_if.sv @@
`timescale 1ns / 1ps

interface efd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic [3:0]  byte_kind;
  logic [3:0]  value_tag;
  logic [63:0] fixed_value;
  logic        value_complete;
  logic        frame_last;
  logic [2:0]  status;

  modport source (output valid, output byte_out, output byte_kind, output value_tag,
                  output fixed_value, output value_complete, output frame_last,
                  output status, input ready);
  modport sink (input valid, input byte_out, input byte_kind, input value_tag,
                input fixed_value, input value_complete, input frame_last,
                input status, output ready);
endinterface

@@ rtl/core/efd_cfg.sv @@
`timescale 1ns / 1ps

module efd_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [efd_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output efd_pkg::cfg_t               cfg
);

  efd_pkg::cfg_t cfg_r, cfg_nxt;
  logic          wr_en;

  assign wr_en = psel && penable && pwrite;

  // Register write decode on the access phase.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[2])
        efd_pkg::RegMaxMsg: cfg_nxt.max_message_bytes      = pwdata;
        efd_pkg::RegMaxHdr: cfg_nxt.max_header_block_bytes = pwdata;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_message_bytes      <= efd_pkg::MaxMsgReset;
      cfg_r.max_header_block_bytes <= efd_pkg::MaxHdrReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux.
  assign prdata = (paddr[2] == efd_pkg::RegMaxHdr) ? cfg_r.max_header_block_bytes
                                                   : cfg_r.max_message_bytes;
  assign cfg    = cfg_r;

endmodule

@@ rtl/core/efd_parse.sv @@
`timescale 1ns / 1ps

module efd_parse (
  input  logic           clk,
  input  logic           rst_n,
  efd_in_if.sink         in_ch,
  input  logic           take_ok,
  input  efd_pkg::cfg_t  cfg,
  output logic           res_load,
  output efd_pkg::res_t  res
);

  efd_pkg::phase_t phase_r, phase_nxt;
  efd_pkg::fault_t fault_r, fault_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] hdrs_r, hdrs_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] snap_r, snap_nxt;
  logic [31:0] rcrc_r, rcrc_nxt;
  logic [31:0] hleft_r, hleft_nxt;
  logic [15:0] fleft_r, fleft_nxt;
  logic [3:0]  tag_r, tag_nxt;
  logic [63:0] shift_r, shift_nxt;
  logic        halted_r, halted_nxt;

  logic [7:0]  b;
  logic [31:0] crc_upd, rem, pos_inc, tot_m4, rcrc_sh;
  logic [15:0] fleft_dec;
  logic [63:0] shift_sh;
  logic [16:0] need;
  logic        fixed_len;

  assign in_ch.ready = take_ok;
  assign res_load    = in_ch.valid && take_ok;
  assign b           = in_ch.data_byte;

  // Shared arithmetic for this byte.
  assign crc_upd   = efd_pkg::crc_tbl(crc_r[7:0] ^ b) ^ {8'd0, crc_r[31:8]};
  assign rem       = hleft_r - 32'd1;
  assign pos_inc   = pos_r + 32'd1;
  assign tot_m4    = total_r - 32'd4;
  assign rcrc_sh   = {rcrc_r[23:0], b};
  assign fleft_dec = fleft_r - 16'd1;
  assign shift_sh  = {shift_r[55:0], b};

  // Value byte count implied by the tag.
  always_comb begin
    fixed_len = 1'b1;
    unique case (b)
      8'd2:                          need = 17'd1;
      8'd3:                          need = 17'd2;
      8'd4:                          need = 17'd4;
      8'd5, 8'd8:                    need = 17'd8;
      efd_pkg::WireUuid:             need = 17'd16;
      efd_pkg::WireByteArray,
      efd_pkg::WireString: begin
        need      = 17'd2;
        fixed_len = 1'b0;
      end
      default:                       need = 17'd0;
    endcase
  end

  // Next state and result for the accepted byte.
  always_comb begin
    phase_nxt  = phase_r;
    fault_nxt  = fault_r;
    pos_nxt    = pos_r;
    total_nxt  = total_r;
    hdrs_nxt   = hdrs_r;
    crc_nxt    = crc_r;
    snap_nxt   = snap_r;
    rcrc_nxt   = rcrc_r;
    hleft_nxt  = hleft_r;
    fleft_nxt  = fleft_r;
    tag_nxt    = tag_r;
    shift_nxt  = shift_r;
    halted_nxt = halted_r;

    res                = '0;
    res.byte_out       = b;
    res.byte_kind      = efd_pkg::KindDiscard;
    res.status         = efd_pkg::StatOk;

    if (halted_r) begin
      res.status = efd_pkg::StatHalted;
    end else begin
      if (phase_r != efd_pkg::PH_MCRC) begin
        crc_nxt = crc_upd;
      end
      unique case (phase_r)
        efd_pkg::PH_PRELUDE: begin
          if (pos_r < 32'd4) begin
            res.byte_kind = efd_pkg::KindLenPrelude;
            total_nxt     = {total_r[23:0], b};
          end else if (pos_r < 32'd8) begin
            res.byte_kind = efd_pkg::KindLenPrelude;
            hdrs_nxt      = {hdrs_r[23:0], b};
            if (pos_r == 32'd7) begin
              snap_nxt = crc_upd ^ efd_pkg::CrcOnes;
            end
          end else begin
            res.byte_kind = efd_pkg::KindPreludeCrc;
            rcrc_nxt      = rcrc_sh;
          end
          if (pos_r == efd_pkg::PreludeBytes - 32'd1) begin
            if (rcrc_sh != snap_r) begin
              res.status = efd_pkg::StatPreCrc;
            end else if (total_r > cfg.max_message_bytes ||
                         total_r < efd_pkg::OverheadBytes ||
                         hdrs_r > cfg.max_header_block_bytes ||
                         hdrs_r > total_r - efd_pkg::OverheadBytes) begin
              res.status = efd_pkg::StatBounds;
            end else begin
              hleft_nxt = hdrs_r;
              tag_nxt   = 4'd0;
              fault_nxt = efd_pkg::FAULT_NONE;
              if (hdrs_r != 32'd0) begin
                phase_nxt = efd_pkg::PH_NAME_LEN;
              end else if (pos_inc == tot_m4) begin
                phase_nxt = efd_pkg::PH_MCRC;
              end else begin
                phase_nxt = efd_pkg::PH_PAYLOAD;
              end
            end
            if (res.status != efd_pkg::StatOk) begin
              res.frame_last = 1'b1;
              halted_nxt     = 1'b1;
            end
          end
        end

        efd_pkg::PH_NAME_LEN, efd_pkg::PH_NAME, efd_pkg::PH_TAG,
        efd_pkg::PH_VAL_LEN, efd_pkg::PH_VAL_DATA, efd_pkg::PH_SKIP: begin
          hleft_nxt = rem;
          unique case (phase_r)
            efd_pkg::PH_NAME_LEN: begin
              res.byte_kind = efd_pkg::KindNameLen;
              tag_nxt       = 4'd0;
              if (b == 8'd0 || {24'd0, b} > rem) begin
                fault_nxt = efd_pkg::FAULT_NAME;
                phase_nxt = efd_pkg::PH_SKIP;
              end else begin
                fleft_nxt = {8'd0, b};
                phase_nxt = efd_pkg::PH_NAME;
              end
            end
            efd_pkg::PH_NAME: begin
              res.byte_kind = efd_pkg::KindName;
              fleft_nxt     = fleft_dec;
              if (fleft_dec == 16'd0) begin
                if (rem == 32'd0) begin
                  fault_nxt = efd_pkg::FAULT_VALUE;
                  phase_nxt = efd_pkg::PH_SKIP;
                end else begin
                  phase_nxt = efd_pkg::PH_TAG;
                end
              end
            end
            efd_pkg::PH_TAG: begin
              res.byte_kind = efd_pkg::KindTag;
              shift_nxt     = 64'd0;
              tag_nxt       = (b <= efd_pkg::WireUuid) ? b[3:0] : 4'd0;
              res.value_tag = tag_nxt;
              if (b == 8'd0 || b == 8'd1) begin
                res.value_complete = 1'b1;
                phase_nxt          = efd_pkg::PH_NAME_LEN;
              end else if (need == 17'd0) begin
                fault_nxt = efd_pkg::FAULT_VALUE;
                phase_nxt = efd_pkg::PH_SKIP;
              end else if ({15'd0, need} > rem) begin
                fault_nxt = efd_pkg::FAULT_VALUE;
                phase_nxt = efd_pkg::PH_SKIP;
              end else begin
                fleft_nxt = need[15:0];
                phase_nxt = fixed_len ? efd_pkg::PH_VAL_DATA : efd_pkg::PH_VAL_LEN;
              end
            end
            efd_pkg::PH_VAL_LEN: begin
              res.byte_kind = efd_pkg::KindValLen;
              res.value_tag = tag_r;
              shift_nxt     = shift_sh;
              fleft_nxt     = fleft_dec;
              if (fleft_dec == 16'd0) begin
                shift_nxt = 64'd0;
                if ({16'd0, shift_sh[15:0]} > rem) begin
                  fault_nxt = efd_pkg::FAULT_VALUE;
                  phase_nxt = efd_pkg::PH_SKIP;
                end else if (shift_sh[15:0] == 16'd0) begin
                  res.value_complete = 1'b1;
                  phase_nxt          = efd_pkg::PH_NAME_LEN;
                end else begin
                  fleft_nxt = shift_sh[15:0];
                  phase_nxt = efd_pkg::PH_VAL_DATA;
                end
              end
            end
            efd_pkg::PH_VAL_DATA: begin
              res.byte_kind = efd_pkg::KindValData;
              res.value_tag = tag_r;
              shift_nxt     = shift_sh;
              if (tag_r != efd_pkg::WireByteArray[3:0] && tag_r != efd_pkg::WireString[3:0]) begin
                res.fixed_value = shift_sh;
              end
              fleft_nxt = fleft_dec;
              if (fleft_dec == 16'd0) begin
                res.value_complete = 1'b1;
                phase_nxt          = efd_pkg::PH_NAME_LEN;
              end
            end
            default: begin
              res.byte_kind = efd_pkg::KindDiscard;
            end
          endcase
          // Leave the header block once its last byte is in.
          if (rem == 32'd0) begin
            phase_nxt = (pos_inc == tot_m4) ? efd_pkg::PH_MCRC : efd_pkg::PH_PAYLOAD;
          end
        end

        efd_pkg::PH_PAYLOAD: begin
          res.byte_kind = efd_pkg::KindPayload;
          if (pos_inc == tot_m4) begin
            phase_nxt = efd_pkg::PH_MCRC;
          end
        end

        default: begin
          res.byte_kind = efd_pkg::KindMsgCrc;
          rcrc_nxt      = rcrc_sh;
          if (pos_inc == total_r) begin
            res.frame_last = 1'b1;
            if ((crc_r ^ efd_pkg::CrcOnes) != rcrc_sh) begin
              res.status = efd_pkg::StatMsgCrc;
            end else if (fault_r == efd_pkg::FAULT_NAME) begin
              res.status = efd_pkg::StatBadName;
            end else if (fault_r == efd_pkg::FAULT_VALUE) begin
              res.status = efd_pkg::StatBadValue;
            end
            if (res.status != efd_pkg::StatOk) begin
              halted_nxt = 1'b1;
            end
          end
        end
      endcase

      // A clean frame end rearms for the next prelude.
      if (!halted_nxt && res.frame_last) begin
        phase_nxt = efd_pkg::PH_PRELUDE;
        fault_nxt = efd_pkg::FAULT_NONE;
        pos_nxt   = 32'd0;
        total_nxt = 32'd0;
        hdrs_nxt  = 32'd0;
        crc_nxt   = efd_pkg::CrcOnes;
        snap_nxt  = 32'd0;
        rcrc_nxt  = 32'd0;
        hleft_nxt = 32'd0;
        fleft_nxt = 16'd0;
        tag_nxt   = 4'd0;
        shift_nxt = 64'd0;
      end else begin
        pos_nxt = pos_inc;
      end
    end
  end

  // State registers advance on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= efd_pkg::PH_PRELUDE;
      fault_r  <= efd_pkg::FAULT_NONE;
      pos_r    <= 32'd0;
      total_r  <= 32'd0;
      hdrs_r   <= 32'd0;
      crc_r    <= efd_pkg::CrcOnes;
      snap_r   <= 32'd0;
      rcrc_r   <= 32'd0;
      hleft_r  <= 32'd0;
      fleft_r  <= 16'd0;
      tag_r    <= 4'd0;
      shift_r  <= 64'd0;
      halted_r <= 1'b0;
    end else if (res_load) begin
      phase_r  <= phase_nxt;
      fault_r  <= fault_nxt;
      pos_r    <= pos_nxt;
      total_r  <= total_nxt;
      hdrs_r   <= hdrs_nxt;
      crc_r    <= crc_nxt;
      snap_r   <= snap_nxt;
      rcrc_r   <= rcrc_nxt;
      hleft_r  <= hleft_nxt;
      fleft_r  <= fleft_nxt;
      tag_r    <= tag_nxt;
      shift_r  <= shift_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

@@ rtl/core/efd_out_stage.sv @@
`timescale 1ns / 1ps

module efd_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_load,
  input  efd_pkg::res_t res,
  output logic          take_ok,
  efd_out_if.source     out_ch
);

  logic          valid_r, valid_nxt;
  efd_pkg::res_t data_r;

  // A new beat may enter whenever the stage is empty or the held one leaves this cycle.
  assign take_ok   = !valid_r || out_ch.ready;
  assign valid_nxt = res_load || (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      data_r <= res;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.byte_out       = data_r.byte_out;
  assign out_ch.byte_kind      = data_r.byte_kind;
  assign out_ch.value_tag      = data_r.value_tag;
  assign out_ch.fixed_value    = data_r.fixed_value;
  assign out_ch.value_complete = data_r.value_complete;
  assign out_ch.frame_last     = data_r.frame_last;
  assign out_ch.status         = data_r.status;

endmodule

@@ rtl/core/event_frame_deframer.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Width       Contents
// in_ch     in   8           data_byte, one raw stream byte per beat
// out_ch    out  8+4+4+64+5  classified byte, tag, fixed value, flags, status
// cfg_*     i/o  32          APB registers max_message_bytes, max_header_block_bytes
//
// One byte per clock while the sink takes results: the frame parser and its byte-wise
// CRC table update all state in the cycle the byte is accepted, and the result lands
// in one output register. The output register frees in the same cycle it is taken,
// so a stalled sink only holds off the input.
// Reset (rst_n, synchronous) clears the parser to await a prelude.
module event_frame_deframer (
  input  logic                         clk,
  input  logic                         rst_n,
  efd_in_if.sink                       in_ch,
  efd_out_if.source                    out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [efd_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  efd_pkg::cfg_t cfg;
  efd_pkg::res_t res;
  logic          res_load;
  logic          take_ok;

  assign cfg_pready = 1'b1;

  efd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  efd_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .take_ok  (take_ok),
    .cfg      (cfg),
    .res_load (res_load),
    .res      (res)
  );

  efd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_load (res_load),
    .res      (res),
    .take_ok  (take_ok),
    .out_ch   (out_ch)
  );

endmodule
